// ===== design/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine package
// Command, status and cell operation codes shared by the list cells and the
// top level.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int CmdBits    = 2;
  localparam int PosBits    = 5;
  localparam int OutValBits = 32;
  localparam int LenBits    = 6;
  localparam int StatBits   = 2;

  typedef enum logic [CmdBits-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_REMOVE     = 2'd2,
    CMD_READ       = 2'd3
  } cmd_t;

  typedef enum logic [StatBits-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic     update;
    cell_op_t op;
  } cell_ctl_t;

endpackage

// ===== design/olist_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry and takes a new value, its lower neighbor's value or
// its upper neighbor's value when the top level tells it to.
// ----------------------------------------------------------------------------
module olist_cell
  import olist_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [VALUE_BITS-1:0] load_val,
  input  logic [VALUE_BITS-1:0] lower_val,
  input  logic [VALUE_BITS-1:0] upper_val,
  output logic [VALUE_BITS-1:0] cell_val
);

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.update) begin
      case (ctl.op)
        CELL_LOAD:       val_nxt = load_val;
        CELL_FROM_LOWER: val_nxt = lower_val;
        CELL_FROM_UPPER: val_nxt = upper_val;
        default:         val_nxt = val_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign cell_val = val_r;

endmodule

// ===== design/ordered_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded double-ended list of signed values held in a row of cells.
// ----------------------------------------------------------------------------
// Each input word carries a command (push front, push back, remove at a
// position, read at a position), a value and a position. Every command
// returns exactly one output word with the removed or read value, the list
// length after the command and a status (done, list full, position out of
// range). A failed command leaves the list unchanged.
// All cells shift in parallel, so a command completes in the cycle it is
// accepted and its result appears in the output register in the next cycle.
// Throughput is one word per cycle while the receiver takes results; the
// output register is the only stage, and a new word is taken whenever it is
// empty or being emptied in the same cycle.
// When the receiver stalls, the result holds and in_ready drops until it is
// taken. Reset empties the list and the output register; entry contents are
// not cleared, since only entries below the length are ever read.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit
  import olist_pkg::*;
#(
  parameter int CAPACITY   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CmdBits-1:0]           in_command,
  input  logic signed [31:0]           in_value,
  input  logic [PosBits-1:0]           in_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OutValBits-1:0] out_read_value,
  output logic [LenBits-1:0]           out_length,
  output logic [StatBits-1:0]          out_status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > PosBits) ? CW : PosBits;

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  logic [OutValBits-1:0] rd_val_r;
  logic [OutValBits-1:0] rd_val_nxt;
  logic [LenBits-1:0]    len_r;
  logic [StatBits-1:0]   stat_r;
  status_t               stat_nxt;

  logic                  accept;
  cmd_t                  cmd;
  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         cnt_x;
  logic                  full;
  logic                  in_range;
  logic [63:0]           val_sx;
  logic [VALUE_BITS-1:0] push_val;
  logic [VALUE_BITS-1:0] sel_val;
  logic [63:0]           sel_ext;

  logic [VALUE_BITS-1:0] cell_vals [CAPACITY];

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign cmd      = cmd_t'(in_command);
  assign pos_x    = PW'(in_position);
  assign cnt_x    = PW'(count_r);
  assign full     = (count_r == CW'(CAPACITY));
  assign in_range = (pos_x < cnt_x);
  assign val_sx   = {{32{in_value[31]}}, in_value};
  assign push_val = val_sx[VALUE_BITS-1:0];
  assign sel_val  = cell_vals[pos_x[IW-1:0]];
  assign sel_ext  = 64'(sel_val);

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VALUE_BITS-1:0] lower_val;
    logic [VALUE_BITS-1:0] upper_val;
    cell_ctl_t             cell_ctl;

    if (k == 0) begin : g_first
      assign lower_val = push_val;
    end else begin : g_lower
      assign lower_val = cell_vals[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign upper_val = cell_vals[k];
    end else begin : g_upper
      assign upper_val = cell_vals[k+1];
    end

    always_comb begin
      cell_ctl.update = accept;
      cell_ctl.op     = CELL_HOLD;
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (!full) begin
            cell_ctl.op = (k == 0) ? CELL_LOAD : CELL_FROM_LOWER;
          end
        end
        CMD_PUSH_BACK: begin
          if (!full && (PW'(k) == cnt_x)) begin
            cell_ctl.op = CELL_LOAD;
          end
        end
        CMD_REMOVE: begin
          if (in_range && (PW'(k) >= pos_x)) begin
            cell_ctl.op = CELL_FROM_UPPER;
          end
        end
        default: cell_ctl.op = CELL_HOLD;
      endcase
    end

    olist_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .load_val (push_val),
      .lower_val(lower_val),
      .upper_val(upper_val),
      .cell_val (cell_vals[k])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    rd_val_nxt = '0;
    stat_nxt   = ST_DONE;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          stat_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (in_range) begin
          rd_val_nxt = sel_ext[OutValBits-1:0];
          count_nxt  = count_r - CW'(1);
        end else begin
          stat_nxt = ST_RANGE;
        end
      end
      default: begin
        if (in_range) begin
          rd_val_nxt = sel_ext[OutValBits-1:0];
        end else begin
          stat_nxt = ST_RANGE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_val_r <= rd_val_nxt;
      len_r    <= LenBits'(count_nxt);
      stat_r   <= stat_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = rd_val_r;
  assign out_length     = len_r;
  assign out_status     = stat_r;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives push, remove and read commands through the valid/ready input channel
// and checks every output word against a predictor that keeps its own copy
// of the list. Directed tests cover the empty list, value extremes, a full
// list and positions past the end. Random traffic then moves the list length
// up and down while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import olist_pkg::*;

  localparam int LIST_CAP       = 32;
  localparam int RANDOM_WORDS   = 640;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic signed [OutValBits-1:0] read_value;
    logic [LenBits-1:0]           length;
    status_t                      status;
  } list_result_t;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  logic [CmdBits-1:0]           in_command     = CMD_READ;
  logic signed [31:0]           in_value       = '0;
  logic [PosBits-1:0]           in_position    = '0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  logic signed [OutValBits-1:0] out_read_value;
  logic [LenBits-1:0]           out_length;
  logic [StatBits-1:0]          out_status;

  logic signed [31:0] list_vals [LIST_CAP];
  int                 list_len = 0;
  list_result_t       expected_results [$];

  int errors       = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;
  bit tx_gaps_en   = 1'b1;
  bit rx_stall_en  = 1'b1;
  int push_words   = 0;
  int remove_words = 0;
  int read_words   = 0;
  int full_seen    = 0;
  int range_seen   = 0;
  int checked      = 0;
  int peak_len     = 0;

  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_age   = 0;

  ordered_list_engine_unit #(
    .CAPACITY  (LIST_CAP),
    .VALUE_BITS(32)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_value(out_read_value),
    .out_length    (out_length),
    .out_status    (out_status)
  );

  always #5 clk = ~clk;

  function automatic list_result_t predict_list_result(input cmd_t c,
                                                       input logic signed [31:0] v,
                                                       input logic [PosBits-1:0] p);
    list_result_t r;
    r.read_value = '0;
    r.status     = ST_DONE;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (list_len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else if (c == CMD_PUSH_FRONT) begin
          for (int k = list_len; k > 0; k--) list_vals[k] = list_vals[k-1];
          list_vals[0] = v;
          list_len++;
        end else begin
          list_vals[list_len] = v;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = list_vals[p];
          for (int k = p; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
          list_len--;
        end
      end
      default: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = list_vals[p];
        end
      end
    endcase
    r.length = list_len[LenBits-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    bit           moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        got   = '{out_read_value, out_length, status_t'(out_status)};
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word: read_value %0d length %0d status %0d",
                   $time, got.read_value, got.length, got.status);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.read_value !== want.read_value) begin
            errors++;
            $display("%0t: read_value mismatch: expected %0d, actual %0d",
                     $time, want.read_value, got.read_value);
          end
          if (got.length !== want.length) begin
            errors++;
            $display("%0t: length mismatch: expected %0d, actual %0d",
                     $time, want.length, got.length);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        want  = predict_list_result(cmd_t'(in_command), in_value, in_position);
        expected_results.push_back(want);
        case (cmd_t'(in_command))
          CMD_PUSH_FRONT, CMD_PUSH_BACK: push_words++;
          CMD_REMOVE:                    remove_words++;
          default:                       read_words++;
        endcase
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_RANGE) range_seen++;
        if (list_len > peak_len) peak_len = list_len;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (pat_age == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pat = 16'hFFFF;
        1:       ready_pat = 16'($urandom) | 16'h1111;
        2:       ready_pat = 16'($urandom & $urandom) | 16'h0001;
        default: ready_pat = 16'($urandom);
      endcase
      if (!rx_stall_en) ready_pat = 16'hFFFF;
      pat_age = $urandom_range(8, 64);
    end
    out_ready = ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[15:1]};
    pat_age--;
  end

  task automatic send_word(input cmd_t c, input logic signed [31:0] v,
                           input logic [PosBits-1:0] p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (tx_gaps_en) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    in_valid    = 1'b1;
    in_command  = c;
    in_value    = v;
    in_position = p;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PosBits-1:0] pick_position(input bit in_range);
    if (list_len >= LIST_CAP) return PosBits'($urandom);
    if (in_range && list_len > 0) return PosBits'($urandom_range(0, list_len - 1));
    return PosBits'($urandom_range(list_len, LIST_CAP - 1));
  endfunction

  task automatic test_empty_list();
    send_word(CMD_READ, '0, 5'd0);
    send_word(CMD_REMOVE, '0, 5'd0);
    send_word(CMD_READ, -32'sd1, 5'd31);
    send_word(CMD_REMOVE, -32'sd1, 5'd31);
  endtask

  task automatic test_push_remove_read();
    send_word(CMD_PUSH_BACK, 32'sh7FFF_FFFF, 5'd31);
    send_word(CMD_PUSH_FRONT, 32'sh8000_0000, 5'd0);
    send_word(CMD_PUSH_BACK, -32'sd1, 5'd0);
    send_word(CMD_PUSH_FRONT, '0, 5'd31);
    send_word(CMD_PUSH_BACK, 32'sh5A5A_A5A5, 5'd10);
    for (int k = 0; k < 5; k++) send_word(CMD_READ, '0, PosBits'(k));
    send_word(CMD_READ, '0, 5'd5);
    send_word(CMD_REMOVE, '0, 5'd2);
    send_word(CMD_REMOVE, '0, 5'd0);
    send_word(CMD_REMOVE, '0, PosBits'(list_len - 1));
    send_word(CMD_REMOVE, '0, PosBits'(list_len));
    while (list_len > 0) send_word(CMD_REMOVE, '0, 5'd0);
  endtask

  task automatic test_full_list();
    while (list_len < LIST_CAP) begin
      send_word(cmd_t'($urandom_range(0, 1)), rand_value(), PosBits'($urandom));
    end
    send_word(CMD_PUSH_FRONT, rand_value(), 5'd0);
    send_word(CMD_PUSH_BACK, rand_value(), 5'd31);
    send_word(CMD_READ, '0, 5'd31);
    send_word(CMD_READ, '0, 5'd0);
    send_word(CMD_REMOVE, '0, 5'd31);
    send_word(CMD_REMOVE, '0, 5'd0);
    send_word(CMD_PUSH_FRONT, rand_value(), 5'd0);
    send_word(CMD_PUSH_BACK, rand_value(), 5'd0);
    send_word(CMD_PUSH_BACK, rand_value(), 5'd0);
    while (list_len > 0) begin
      send_word(CMD_REMOVE, rand_value(), PosBits'($urandom_range(0, list_len - 1)));
    end
  endtask

  task automatic test_random_traffic();
    int  phase_left;
    int  mode;
    int  push_pct;
    bit  do_push;
    phase_left = 0;
    mode       = 0;
    push_pct   = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        mode        = $urandom_range(0, 3);
        phase_left  = $urandom_range(20, 80);
        tx_gaps_en  = ($urandom_range(0, 2) != 0);
        rx_stall_en = ($urandom_range(0, 2) != 0);
        case (mode)
          0:       push_pct = 70;
          1:       push_pct = 25;
          default: push_pct = 48;
        endcase
      end
      phase_left--;
      do_push = ($urandom_range(0, 99) < push_pct);
      if (mode == 3 && $urandom_range(0, 3) == 0) begin
        send_word(cmd_t'($urandom_range(0, 3)), $urandom, PosBits'($urandom));
      end else if (do_push) begin
        send_word($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, rand_value(),
                  PosBits'($urandom));
      end else begin
        send_word($urandom_range(0, 1) ? CMD_REMOVE : CMD_READ, rand_value(),
                  pick_position($urandom_range(0, 99) < 85));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_list();
    test_push_remove_read();
    test_full_list();
    tx_gaps_en  = 1'b0;
    rx_stall_en = 1'b0;
    test_full_list();
    tx_gaps_en  = 1'b1;
    rx_stall_en = 1'b1;
    test_random_traffic();

    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end

    $display("Sent %0d pushes, %0d removes and %0d reads; checked %0d result words.",
             push_words, remove_words, read_words, checked);
    $display("Saw %0d full-list and %0d out-of-range results, peak length %0d, %0d errors.",
             full_seen, range_seen, peak_len, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
